// ===== src/slfd_pkg.sv =====
// Shared constants, register indexes and types of the sensor link fault detector.
package slfd_pkg;

  // History window size and the widths that follow from it.
  localparam int MAX_WINDOW = 32;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W      = $clog2(MAX_WINDOW);

  // Register field widths.
  localparam int BLOCK_THR_W   = 8;
  localparam int RECOVER_THR_W = 5;
  localparam int WINDOW_LEN_W  = 5;
  localparam int COUNT_W       = 8;

  // Common width for comparing window counts against register values.
  localparam int CMP_W = (FILL_W > RECOVER_THR_W) ? FILL_W : RECOVER_THR_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_THR   = 2'd0,
    CFG_RECOVER_THR = 2'd1,
    CFG_WINDOW_LEN  = 2'd2
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [BLOCK_THR_W-1:0]   BLOCK_THR_RST   = 8'd6;
  localparam logic [RECOVER_THR_W-1:0] RECOVER_THR_RST = 5'd17;
  localparam logic [WINDOW_LEN_W-1:0]  WINDOW_LEN_RST  = 5'd22;

  typedef struct packed {
    logic [BLOCK_THR_W-1:0]   block_thr;
    logic [RECOVER_THR_W-1:0] recover_thr;
    logic [WINDOW_LEN_W-1:0]  window_len;
  } cfg_t;

  typedef struct packed {
    logic fault_active;
    logic frame_accepted;
    logic fault_entered;
    logic fault_recovered;
  } status_t;

endpackage

// ===== src/slfd_ifs.sv =====
// Handshake interfaces for the frame request and the status result channels.
interface slfd_frame_if;
  logic valid;
  logic ready;
  logic frame_good;

  modport source (output valid, output frame_good, input ready);
  modport sink   (input valid, input frame_good, output ready);
endinterface

interface slfd_status_if;
  logic valid;
  logic ready;
  logic fault_active;
  logic frame_accepted;
  logic fault_entered;
  logic fault_recovered;

  modport source (output valid, output fault_active, output frame_accepted,
                  output fault_entered, output fault_recovered, input ready);
  modport sink   (input valid, input fault_active, input frame_accepted,
                  input fault_entered, input fault_recovered, output ready);
endinterface

// ===== src/slfd_cfg_regs.sv =====
// Configuration registers of the sensor link fault detector.
module slfd_cfg_regs
  import slfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_THR:   cfg_d.block_thr   = cfg_wdata_i[BLOCK_THR_W-1:0];
        CFG_RECOVER_THR: cfg_d.recover_thr = cfg_wdata_i[RECOVER_THR_W-1:0];
        CFG_WINDOW_LEN:  cfg_d.window_len  = cfg_wdata_i[WINDOW_LEN_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_thr   <= BLOCK_THR_RST;
      cfg_q.recover_thr <= RECOVER_THR_RST;
      cfg_q.window_len  <= WINDOW_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/slfd_in_stage.sv =====
// Input register that holds one frame request until the core consumes it.
module slfd_in_stage
  import slfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  slfd_frame_if.sink  frame_i,
  input  logic        advance_i,
  output logic        item_valid_o,
  output logic        frame_good_o
);

  logic valid_q, valid_d;
  logic good_q;
  logic take;

  // The register can take a new request when empty or when its item moves on.
  assign frame_i.ready = !valid_q || advance_i;
  assign take          = frame_i.valid && frame_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      good_q <= frame_i.frame_good;
    end
  end

  assign item_valid_o = valid_q;
  assign frame_good_o = good_q;

endmodule

// ===== src/slfd_core.sv =====
// Fault detection state and next-state logic, one frame per advance.
module slfd_core
  import slfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    advance_i,
  input  logic    frame_good_i,
  output status_t status_o
);

  logic                  fault_q, fault_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [MAX_WINDOW-1:0] hist_q, hist_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W-1:0]     ones_q, ones_d;

  logic                  full;
  logic [MAX_WINDOW-1:0] bits_push, bits_c, bits_f;
  logic [FILL_W-1:0]     fill_push, fill_c, fill_f, fill_m1;
  logic [FILL_W-1:0]     ones_push, ones_c, ones_f;
  logic [IDX_W-1:0]      drop_idx;
  logic                  recover;
  logic                  shrink;
  logic [COUNT_W-1:0]    count_inc;
  logic                  enter;

  // Window path: push the new entry, test for recovery, then trim to length.
  // The ones count is kept alongside the window so no population count is needed.
  always_comb begin
    full      = (fill_q == FILL_W'(MAX_WINDOW));
    bits_push = {hist_q[MAX_WINDOW-2:0], frame_good_i};
    fill_push = full ? fill_q : fill_q + 1'b1;
    ones_push = ones_q - (full ? FILL_W'(hist_q[MAX_WINDOW-1]) : '0)
                + FILL_W'(frame_good_i);

    recover = frame_good_i && (CMP_W'(ones_push) > CMP_W'(cfg_i.recover_thr));

    bits_c = recover ? '0 : bits_push;
    fill_c = recover ? '0 : fill_push;
    ones_c = recover ? '0 : ones_push;

    fill_m1  = fill_c - 1'b1;
    drop_idx = fill_m1[IDX_W-1:0];
    shrink   = CMP_W'(fill_c) > CMP_W'(cfg_i.window_len);

    bits_f = bits_c;
    fill_f = fill_c;
    ones_f = ones_c;
    if (shrink) begin
      bits_f[drop_idx] = 1'b0;
      fill_f           = fill_m1;
      ones_f           = ones_c - FILL_W'(bits_c[drop_idx]);
    end
  end

  // Normal mode path: count blocked frames against the threshold.
  assign count_inc = count_q + 1'b1;
  assign enter     = !frame_good_i && (count_inc > cfg_i.block_thr);

  // Mode selection and result fields.
  always_comb begin
    fault_d  = fault_q;
    count_d  = count_q;
    hist_d   = hist_q;
    fill_d   = fill_q;
    ones_d   = ones_q;
    status_o = '0;
    if (fault_q) begin
      hist_d = bits_f;
      fill_d = fill_f;
      ones_d = ones_f;
      if (recover) begin
        fault_d                  = 1'b0;
        count_d                  = '0;
        status_o.fault_recovered = 1'b1;
      end
    end else if (frame_good_i) begin
      count_d                 = '0;
      status_o.frame_accepted = 1'b1;
    end else if (enter) begin
      count_d                = '0;
      fault_d                = 1'b1;
      status_o.fault_entered = 1'b1;
    end else begin
      count_d = count_inc;
    end
    status_o.fault_active = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= 1'b0;
      count_q <= '0;
      hist_q  <= '0;
      fill_q  <= '0;
      ones_q  <= '0;
    end else if (advance_i) begin
      fault_q <= fault_d;
      count_q <= count_d;
      hist_q  <= hist_d;
      fill_q  <= fill_d;
      ones_q  <= ones_d;
    end
  end

endmodule

// ===== src/slfd_out_stage.sv =====
// Result register that holds one status result until the consumer takes it.
module slfd_out_stage
  import slfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  status_t       status_i,
  output logic          free_o,
  slfd_status_if.source status_o
);

  logic    valid_q, valid_d;
  status_t data_q;

  // Free when empty or when the held result is taken in this cycle.
  assign free_o = !valid_q || status_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (status_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= status_i;
    end
  end

  assign status_o.valid           = valid_q;
  assign status_o.fault_active    = data_q.fault_active;
  assign status_o.frame_accepted  = data_q.frame_accepted;
  assign status_o.fault_entered   = data_q.fault_entered;
  assign status_o.fault_recovered = data_q.fault_recovered;

endmodule

// ===== src/sensor_link_fault_detector.sv =====
// Path: an accepted frame request is held in the input register, and its status is then
// loaded into the result register when that register is free.
// Throughput: one frame per cycle while the consumer takes each result.
// Reset: asynchronous, active low; normal mode, counters and window cleared,
// registers return to block 6, recover 17, window 22.
module sensor_link_fault_detector
  import slfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slfd_frame_if.sink            frame_i,
  slfd_status_if.source         status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  logic    item_valid;
  logic    frame_good;
  logic    out_free;
  logic    advance;
  status_t status;

  // An item moves from the input register to the result register when both allow it.
  assign advance = item_valid && out_free;

  slfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slfd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .frame_good_o (frame_good)
  );

  slfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .advance_i    (advance),
    .frame_good_i (frame_good),
    .status_o     (status)
  );

  slfd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .status_i (status),
    .free_o   (out_free),
    .status_o (status_o)
  );

endmodule
